// ===== sv/helmholtz_five_point_stencil_macros.svh =====
// Assertion macros shared by the stencil RTL.
// HFPS_ASSERT checks a property at every clock edge outside reset.
// HFPS_ASSERT_NEXT checks that a condition implies another in the following cycle.
`ifndef HELMHOLTZ_FIVE_POINT_STENCIL_MACROS_SVH
`define HELMHOLTZ_FIVE_POINT_STENCIL_MACROS_SVH

`ifndef SYNTHESIS
`define HFPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
`define HFPS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);
`else
`define HFPS_ASSERT(lbl, clk, rstn, prop, msg)
`define HFPS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// ===== sv/hfps_pkg.sv =====
`timescale 1ns / 1ps

package hfps_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int SIZE_WIDTH      = 7;
  localparam int SIDES_WIDTH     = 4;

  // boundary_sides bit positions
  localparam int SIDE_WEST  = 0;
  localparam int SIDE_EAST  = 1;
  localparam int SIDE_SOUTH = 2;
  localparam int SIDE_NORTH = 3;

  localparam logic [SIZE_WIDTH-1:0]         COLUMNS_RST = SIZE_WIDTH'(16);
  localparam logic [SIZE_WIDTH-1:0]         ROWS_RST    = SIZE_WIDTH'(16);
  localparam logic signed [VALUE_WIDTH-1:0] INV_DX_RST  = VALUE_WIDTH'(65536);
  localparam logic signed [VALUE_WIDTH-1:0] INV_DY_RST  = VALUE_WIDTH'(65536);
  localparam logic signed [VALUE_WIDTH-1:0] DIAG_RST    = -VALUE_WIDTH'(65536);
  localparam logic [SIDES_WIDTH-1:0]        SIDES_RST   = SIDES_WIDTH'(15);

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_PATCH_COLUMNS  = 3'd0,
    REG_PATCH_ROWS     = 3'd1,
    REG_INV_DX_SQUARED = 3'd2,
    REG_INV_DY_SQUARED = 3'd3,
    REG_DIAG_SHIFT     = 3'd4,
    REG_BOUNDARY_SIDES = 3'd5
  } hfps_reg_e;

  // Per-cell control that travels with an interior cell into the datapath.
  typedef struct packed {
    logic west_rep;
    logic east_rep;
    logic south_rep;
    logic north_rep;
    logic last;
  } hfps_flags_t;

endpackage

// ===== sv/hfps_line_buffer.sv =====
`timescale 1ns / 1ps

module hfps_line_buffer #(
  parameter int DEPTH = hfps_pkg::MAX_COLUMNS_DEF + 2
) (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          col_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]  wdata_i,
  input  logic                              above_we_i,
  input  logic [$clog2(DEPTH)-1:0]          above_addr_i,
  output logic [hfps_pkg::VALUE_WIDTH-1:0]  center_o,
  output logic [hfps_pkg::VALUE_WIDTH-1:0]  east_o,
  output logic [hfps_pkg::VALUE_WIDTH-1:0]  south_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int VW = hfps_pkg::VALUE_WIDTH;

  logic [VW-1:0] mid_mem   [DEPTH];
  logic [VW-1:0] above_mem [DEPTH];

  logic [VW-1:0] center_q, east_q, south_q;
  logic [AW-1:0] east_addr;

  // last column has no east neighbor in the buffer
  assign east_addr = (col_i == AW'(DEPTH - 1)) ? col_i : col_i + AW'(1);

  // read-first: the new cell lands in the middle row after its old value is read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      center_q         <= mid_mem[col_i];
      east_q           <= mid_mem[east_addr];
      south_q          <= above_mem[col_i];
      mid_mem[col_i]   <= wdata_i;
    end
  end

  // old middle row value moves up once its cell leaves stage one
  always_ff @(posedge clk_i) begin
    if (above_we_i) begin
      above_mem[above_addr_i] <= center_q;
    end
  end

  assign center_o = center_q;
  assign east_o   = east_q;
  assign south_o  = south_q;

endmodule

// ===== sv/hfps_datapath.sv =====
`timescale 1ns / 1ps

module hfps_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  hfps_pkg::hfps_flags_t                    flags_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]         center_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]         west_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]         east_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]         south_i,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]         north_i,
  input  logic signed [hfps_pkg::VALUE_WIDTH-1:0]  inv_dx_sq_i,
  input  logic signed [hfps_pkg::VALUE_WIDTH-1:0]  inv_dy_sq_i,
  input  logic signed [hfps_pkg::VALUE_WIDTH-1:0]  diag_shift_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [hfps_pkg::VALUE_WIDTH-1:0]         out_value_o,
  output logic                                     out_last_o
);

  localparam int VW   = hfps_pkg::VALUE_WIDTH;
  localparam int FRAC = hfps_pkg::FRAC_BITS;
  localparam int DW   = VW + 2;   // second difference
  localparam int PW   = DW + VW;  // one product
  localparam int SW   = PW + 2;   // sum of three products

  localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW - 1){1'b0}}};

  logic v2_q, v3_q, v4_q, v5_q;
  logic rdy2, rdy3, rdy4, rdy5;

  logic [VW-1:0] w_sel, e_sel, s_sel, n_sel;
  logic signed [DW-1:0] cx, wx, ex, sx, nx;
  logic signed [DW-1:0] dx_d, dy_d;

  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [VW-1:0] ctr2_q;
  logic                 last2_q;

  logic signed [PW-1:0] px3_q, py3_q, pd3_q;
  logic                 last3_q;

  logic signed [SW-1:0] sum4_q;
  logic                 last4_q;

  logic [SW-FRAC-VW:0]  sum_hi;
  logic                 ovf;
  logic [VW-1:0]        value_d;
  logic [VW-1:0]        value5_q;
  logic                 last5_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  // ghost replacement for physical sides
  always_comb begin
    w_sel = flags_i.west_rep  ? center_i : west_i;
    e_sel = flags_i.east_rep  ? center_i : east_i;
    s_sel = flags_i.south_rep ? center_i : south_i;
    n_sel = flags_i.north_rep ? center_i : north_i;
    cx    = $signed({{(DW - VW){center_i[VW-1]}}, center_i});
    wx    = $signed({{(DW - VW){w_sel[VW-1]}}, w_sel});
    ex    = $signed({{(DW - VW){e_sel[VW-1]}}, e_sel});
    sx    = $signed({{(DW - VW){s_sel[VW-1]}}, s_sel});
    nx    = $signed({{(DW - VW){n_sel[VW-1]}}, n_sel});
    dx_d  = wx + ex - (cx <<< 1);
    dy_d  = sx + nx - (cx <<< 1);
  end

  // floor shift is a plain bit select; saturate when the upper bits disagree
  assign sum_hi  = sum4_q[SW-1:FRAC+VW-1];
  assign ovf     = !((&sum_hi) || !(|sum_hi));
  assign value_d = ovf ? (sum4_q[SW-1] ? SAT_MIN : SAT_MAX) : sum4_q[FRAC+VW-1:FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      dx2_q   <= dx_d;
      dy2_q   <= dy_d;
      ctr2_q  <= $signed(center_i);
      last2_q <= flags_i.last;
    end
    if (rdy3) begin
      px3_q   <= dx2_q * inv_dx_sq_i;
      py3_q   <= dy2_q * inv_dy_sq_i;
      pd3_q   <= ctr2_q * diag_shift_i;
      last3_q <= last2_q;
    end
    if (rdy4) begin
      sum4_q  <= px3_q + py3_q + pd3_q;
      last4_q <= last3_q;
    end
    if (rdy5) begin
      value5_q <= value_d;
      last5_q  <= last4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_value_o = value5_q;
  assign out_last_o  = last5_q;

endmodule

// ===== sv/helmholtz_five_point_stencil.sv =====
`timescale 1ns / 1ps
// After north cell transfer, results pass stage one, difference, product, sum, output.
// Throughput: one padded cell per cycle unless back-pressured, paced by the single
//   write port of the middle line buffer, which takes every cell in its transfer cycle.
// Reset (rst_ni, async, active low): registers return to their defaults and the
//   scan position to the south-west ghost corner; line buffers are not cleared,
//   since every entry read for a result is written earlier in the same patch.

`include "helmholtz_five_point_stencil_macros.svh"

module helmholtz_five_point_stencil #(
  parameter int MAX_COLUMNS = hfps_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = hfps_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [hfps_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr_i,
  input  logic [hfps_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i,
  // cell stream in
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [hfps_pkg::VALUE_WIDTH-1:0]     s_axis_tdata_i,  // [31:0] cell_value
  // result stream out
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [hfps_pkg::VALUE_WIDTH-1:0]     m_axis_tdata_o,  // [31:0] result_value
  output logic                                 m_axis_tlast_o   // last_of_patch
);

  localparam int Depth = MAX_COLUMNS + 2;        // interior plus two ghost columns
  localparam int ColW  = $clog2(Depth);
  localparam int RowW  = $clog2(MAX_ROWS + 2);
  localparam int VW    = hfps_pkg::VALUE_WIDTH;
  localparam int SZW   = hfps_pkg::SIZE_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SZW-1:0]                   cols_q, rows_q;
  logic signed [VW-1:0]             inv_dx_q, inv_dy_q, diag_q;
  logic [hfps_pkg::SIDES_WIDTH-1:0] sides_q;

  logic [ColW-1:0] cols_eff;
  logic [RowW-1:0] rows_eff;

  // sizes of zero act as one, sizes beyond the buffers act as the maximum
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = ColW'(1);
    end else if (int'(cols_q) > MAX_COLUMNS) begin
      cols_eff = ColW'(MAX_COLUMNS);
    end else begin
      cols_eff = ColW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = RowW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_eff = RowW'(MAX_ROWS);
    end else begin
      rows_eff = RowW'(rows_q);
    end
  end

  // a size write restarts the scan at the first cell of a new patch
  logic cfg_size_wr;
  assign cfg_size_wr = cfg_we_i &&
                       (cfg_addr_i == hfps_pkg::REG_PATCH_COLUMNS ||
                        cfg_addr_i == hfps_pkg::REG_PATCH_ROWS);

  // ---------------------------------------------------------------------------
  // Scan position of the next cell in the padded patch
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (col_q >= cols_eff + ColW'(1)) begin
      col_d = '0;
      row_d = (row_q >= rows_eff + RowW'(1)) ? '0 : row_q + RowW'(1);
    end
  end

  // Interior cell (col, row-1) is finished by the cell arriving now, its north
  // neighbor. Ghost replacement flags are worked out here and carried along.
  logic                  has_out;
  hfps_pkg::hfps_flags_t flags_d;

  always_comb begin
    has_out = (col_q != '0) && (col_q <= cols_eff) &&
              (row_q >= RowW'(2)) && (row_q <= rows_eff + RowW'(1));
    flags_d.west_rep  = (col_q == ColW'(1)) && sides_q[hfps_pkg::SIDE_WEST];
    flags_d.east_rep  = (col_q == cols_eff) && sides_q[hfps_pkg::SIDE_EAST];
    flags_d.south_rep = (row_q == RowW'(2)) && sides_q[hfps_pkg::SIDE_SOUTH];
    flags_d.north_rep = (row_q == rows_eff + RowW'(1)) && sides_q[hfps_pkg::SIDE_NORTH];
    flags_d.last      = (col_q == cols_eff) && (row_q == rows_eff + RowW'(1));
  end

  // ---------------------------------------------------------------------------
  // Stage one: line buffer read data plus the transferred cell
  // ---------------------------------------------------------------------------
  logic                  v1_q, s1_out_q;
  hfps_pkg::hfps_flags_t s1_flags_q;
  logic [ColW-1:0]       s1_col_q;
  logic [VW-1:0]         north_q, west_q;
  logic [VW-1:0]         center_rd, east_rd, south_rd;
  logic                  dp_ready, dp_valid, s1_go;

  // ghost and edge-row cells leave stage one without entering the datapath
  assign s1_go           = v1_q && (!s1_out_q || dp_ready);
  assign s_axis_tready_o = !v1_q || s1_go;
  assign dp_valid        = v1_q && s1_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= hfps_pkg::COLUMNS_RST;
      rows_q   <= hfps_pkg::ROWS_RST;
      inv_dx_q <= hfps_pkg::INV_DX_RST;
      inv_dy_q <= hfps_pkg::INV_DY_RST;
      diag_q   <= hfps_pkg::DIAG_RST;
      sides_q  <= hfps_pkg::SIDES_RST;
      col_q    <= '0;
      row_q    <= '0;
      v1_q     <= 1'b0;
      s1_out_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (hfps_pkg::hfps_reg_e'(cfg_addr_i))
          hfps_pkg::REG_PATCH_COLUMNS:  cols_q   <= cfg_wdata_i[SZW-1:0];
          hfps_pkg::REG_PATCH_ROWS:     rows_q   <= cfg_wdata_i[SZW-1:0];
          hfps_pkg::REG_INV_DX_SQUARED: inv_dx_q <= $signed(cfg_wdata_i[VW-1:0]);
          hfps_pkg::REG_INV_DY_SQUARED: inv_dy_q <= $signed(cfg_wdata_i[VW-1:0]);
          hfps_pkg::REG_DIAG_SHIFT:     diag_q   <= $signed(cfg_wdata_i[VW-1:0]);
          hfps_pkg::REG_BOUNDARY_SIDES: sides_q  <= cfg_wdata_i[hfps_pkg::SIDES_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cfg_size_wr) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s_axis_tready_o) begin
        v1_q     <= s_axis_tvalid_i;
        s1_out_q <= has_out;
      end
    end
  end

  // West neighbor is the center read by the previous cell of the same row.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      north_q    <= s_axis_tdata_i;
      west_q     <= center_rd;
      s1_col_q   <= col_q;
      s1_flags_q <= flags_d;
    end
  end

  hfps_line_buffer #(
    .DEPTH (Depth)
  ) u_lbuf (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .col_i        (col_q),
    .wdata_i      (s_axis_tdata_i),
    .above_we_i   (s1_go),
    .above_addr_i (s1_col_q),
    .center_o     (center_rd),
    .east_o       (east_rd),
    .south_o      (south_rd)
  );

  // ---------------------------------------------------------------------------
  // Stencil arithmetic and output register
  // ---------------------------------------------------------------------------
  hfps_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dp_valid),
    .in_ready_o   (dp_ready),
    .flags_i      (s1_flags_q),
    .center_i     (center_rd),
    .west_i       (west_q),
    .east_i       (east_rd),
    .south_i      (south_rd),
    .north_i      (north_q),
    .inv_dx_sq_i  (inv_dx_q),
    .inv_dy_sq_i  (inv_dy_q),
    .diag_shift_i (diag_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HFPS_ASSERT(a_col_range, clk_i, rst_ni, col_q <= cols_eff + ColW'(1), "column past east ghost")
  `HFPS_ASSERT(a_row_range, clk_i, rst_ni, row_q <= rows_eff + RowW'(1), "row past north ghost")
  `HFPS_ASSERT_NEXT(a_size_restart, clk_i, rst_ni, cfg_size_wr, col_q == '0 && row_q == '0, "size write did not restart scan")
  `HFPS_ASSERT_NEXT(a_ghost_no_result, clk_i, rst_ni, accept && (col_q == '0 || row_q < RowW'(2)), !dp_valid, "ghost cell sent to datapath")

endmodule
